// File: rtl/pakx_pkg.sv
// ----------------------------------------------------------------------------
// pakx_pkg
// Shared types, constants and the multiply-and-fold helper for the packet
// additive keystream xor block.
// ----------------------------------------------------------------------------
package pakx_pkg;

    localparam int LANES  = 4;
    localparam int LANE_W = 2;

    localparam logic [31:0] KEY_MUL_LO = 32'he7988061;
    localparam logic [31:0] KEY_MUL_HI = 32'hbd9fa5c7;
    localparam logic [31:0] SEQ_MUL_HI = 32'hf3f77d13;
    localparam logic [31:0] SEQ_OFS_LO = 32'h80771ab1;
    localparam logic [31:0] SEQ_OFS_HI = 32'h55f2cc88;
    localparam int          FOLD_SHIFT = 19;

    localparam logic [31:0] SEQ_MUL [LANES] = '{
        32'h905c4577, 32'hb84c88cb, 32'hde0efbf1, 32'h9f614c3d
    };

    // one word travelling down the pipeline
    typedef struct packed {
        logic        first;
        logic [31:0] data;
        logic [2:0]  vb;
    } pakx_item_t;

    // one finished result
    typedef struct packed {
        logic [2:0]  vb;
        logic [31:0] data;
    } pakx_result_t;

    // low32(p) ^ low32(p >> 19) of the full 64-bit product
    function automatic logic [31:0] mul_fold(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b};
        return p[31:0] ^ p[FOLD_SHIFT +: 32];
    endfunction

endpackage

// File: rtl/packet_additive_keystream_xor.sv
// ----------------------------------------------------------------------------
// packet_additive_keystream_xor
// Packet obfuscation cipher: per-lane additive keystream xored onto packet
// words. The same operation encrypts and decrypts.
// ----------------------------------------------------------------------------
// usage:
//   load the 64-bit session key through cfg_wr_en / cfg_wr_data while idle;
//   the two derived key words are multiplied out at the write itself
//   stream packet words in on s_axis; tuser marks the first word of a packet,
//   whose tdata also carries the 64-bit packet sequence number
//   one result leaves on m_axis per input transfer, in order
// timing:
//   one transfer per cycle sustained while s_axis_tready is high; a result is
//   offered once its input has passed the input register, the multiply-fold
//   stage and the shared-term add stage that turn the sequence number into the
//   lane add words; the lane key add and xor feed the result queue write directly
// reset:
//   clears the session key (pass-through mode), the lane keys, the lane
//   phase and the result queue; s_axis_tready is high after reset
// stall:
//   results wait in a FIFO_DEPTH-entry queue; s_axis_tready is decoded from a
//   registered in-flight count and drops only when FIFO_DEPTH words are in
//   flight, so input and output handshakes have no combinational path between them
// ----------------------------------------------------------------------------
module packet_additive_keystream_xor #(
    parameter int FIFO_DEPTH = 8    // at least 5 for one transfer per cycle
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data,    // session_key
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // packet_sequence[63:0], data_word[95:64],
                                         // valid_bytes[98:96], zero[103:99]
    input  logic         s_axis_tuser,   // first_word
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata    // data_word_out[31:0], valid_bytes_out[34:32],
                                         // zero[39:35]
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    // session key and its expansion
    logic [63:0] key_reg;
    logic [31:0] exp2_reg;
    logic [31:0] exp3_reg;
    logic [31:0] exp_word [pakx_pkg::LANES];

    // pipeline
    logic                 s1_valid_reg;
    logic                 s2_valid_reg;
    logic                 s3_valid_reg;
    pakx_pkg::pakx_item_t s1_item_reg;
    pakx_pkg::pakx_item_t s2_item_reg;
    pakx_pkg::pakx_item_t s3_item_reg;
    logic [31:0]          s1_n0_reg;
    logic [31:0]          s1_nh_reg;
    logic [pakx_pkg::LANES-1:0][31:0] add_word;

    // lane state
    logic [31:0]               lane_key_reg [pakx_pkg::LANES];
    logic [31:0]               lane_add_reg [pakx_pkg::LANES];
    logic [pakx_pkg::LANE_W-1:0] phase_reg;

    logic [pakx_pkg::LANE_W-1:0] lane;
    logic [31:0]                 key_sum;
    logic [31:0]                 byte_mask;
    pakx_pkg::pakx_result_t      result;
    pakx_pkg::pakx_result_t      out_item;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            exp2_reg <= '0;
            exp3_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            key_reg  <= cfg_wr_data;
            exp2_reg <= pakx_pkg::mul_fold(pakx_pkg::KEY_MUL_LO, cfg_wr_data[31:0]);
            exp3_reg <= pakx_pkg::mul_fold(pakx_pkg::KEY_MUL_HI, cfg_wr_data[63:32]);
        end
    end

    assign exp_word[0] = key_reg[31:0];
    assign exp_word[1] = key_reg[63:32];
    assign exp_word[2] = exp2_reg;
    assign exp_word[3] = exp3_reg;

    // ---------------- credit count ----------------
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    assign s_axis_tready = (inflight_reg != CNT_W'(FIFO_DEPTH));

    // ---------------- pipeline control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            s1_valid_reg <= in_xfer;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // payload always moves; the valid bits say what it means
    always_ff @(posedge clk)
    begin
        s1_item_reg.first <= s_axis_tuser;
        s1_item_reg.data  <= s_axis_tdata[95:64];
        s1_item_reg.vb    <= s_axis_tdata[98:96];
        s1_n0_reg         <= s_axis_tdata[31:0] + pakx_pkg::SEQ_OFS_LO;
        s1_nh_reg         <= s_axis_tdata[63:32] + pakx_pkg::SEQ_OFS_HI;
        s2_item_reg       <= s1_item_reg;
        s3_item_reg       <= s2_item_reg;
    end

    pakx_seq_mix u_seq_mix (
        .clk      (clk),
        .n0       (s1_n0_reg),
        .nh       (s1_nh_reg),
        .add_word (add_word)
    );

    // ---------------- lane key and xor ----------------
    always_comb
    begin
        lane    = s3_item_reg.first ? '0 : phase_reg;
        key_sum = (s3_item_reg.first ? exp_word[0] : lane_key_reg[lane])
                + (s3_item_reg.first ? add_word[0] : lane_add_reg[lane]);
        for (int b = 0; b < 4; b++)
        begin
            byte_mask[b*8 +: 8] = {8{s3_item_reg.vb > 3'(b)}};
        end
        // zero key means pass-through
        result.data = ((key_reg == '0) ? s3_item_reg.data : (s3_item_reg.data ^ key_sum))
                    & byte_mask;
        result.vb   = s3_item_reg.vb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pakx_pkg::LANES; i++)
            begin
                lane_key_reg[i] <= '0;
            end
            phase_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            if (s3_item_reg.first)
            begin
                for (int i = 1; i < pakx_pkg::LANES; i++)
                begin
                    lane_key_reg[i] <= exp_word[i];
                end
            end
            lane_key_reg[lane] <= key_sum;
            phase_reg          <= lane + pakx_pkg::LANE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_item_reg.first)
        begin
            for (int i = 0; i < pakx_pkg::LANES; i++)
            begin
                lane_add_reg[i] <= add_word[i];
            end
        end
    end

    // ---------------- result queue ----------------
    pakx_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s3_valid_reg),
        .wr_item  (result),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_item  (out_item)
    );

    assign m_axis_tdata = {5'd0, out_item.vb, out_item.data};

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(FIFO_DEPTH))
        else $error("more words in flight than the result queue holds");

    a_first_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_item_reg.first) |=> (phase_reg == pakx_pkg::LANE_W'(1)))
        else $error("first word of a packet did not leave lane phase at one");

    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (inflight_reg != '0))
        else $error("result offered with no word in flight");

    a_pipe_credit: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (inflight_reg != '0))
        else $error("pipeline word not counted in flight");

endmodule

// File: rtl/pakx_seq_mix.sv
// ----------------------------------------------------------------------------
// pakx_seq_mix
// Two-stage datapath that turns a packet sequence number into the four
// per-lane add words: multiply-fold stage, then the shared-term add stage.
// ----------------------------------------------------------------------------
module pakx_seq_mix (
    input  logic                                   clk,
    input  logic [31:0]                            n0,
    input  logic [31:0]                            nh,
    output logic [pakx_pkg::LANES-1:0][31:0]       add_word
);

    logic [pakx_pkg::LANES-1:0][31:0] mf_reg;
    logic [31:0]                      n1_reg;
    logic [pakx_pkg::LANES-1:0][31:0] add_reg;

    // five parallel 32x32 multipliers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pakx_pkg::LANES; i++)
        begin
            mf_reg[i] <= pakx_pkg::mul_fold(pakx_pkg::SEQ_MUL[i], n0);
        end
        n1_reg <= pakx_pkg::mul_fold(nh, pakx_pkg::SEQ_MUL_HI);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < pakx_pkg::LANES; i++)
        begin
            add_reg[i] <= mf_reg[i] + n1_reg;
        end
    end

    assign add_word = add_reg;

endmodule

// File: rtl/pakx_out_fifo.sv
// ----------------------------------------------------------------------------
// pakx_out_fifo
// Small result queue between the cipher pipeline and the output channel.
// ----------------------------------------------------------------------------
module pakx_out_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  pakx_pkg::pakx_result_t wr_item,
    output logic                   rd_valid,
    input  logic                   rd_ready,
    output pakx_pkg::pakx_result_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pakx_pkg::pakx_result_t mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   pop;

    assign rd_valid = (count_reg != '0);
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr_en && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule
